[sv/field_oriented_omni_drive_mixer_unit_defines.svh]
// Assertion macros for the omni drive mixer.
`ifndef FIELD_ORIENTED_OMNI_DRIVE_MIXER_UNIT_DEFINES_SVH
`define FIELD_ORIENTED_OMNI_DRIVE_MIXER_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define FODM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed (same cycle)");

// next-cycle implication, checked out of reset
`define FODM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed (next cycle)");

`endif

[sv/fodm_pkg.sv]
// Shared constants, types and the arctangent table of the omni drive mixer.
package fodm_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_ENTRIES  = 24;
  localparam int NUM_ROT       = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES
                                                                : ATAN_ENTRIES;
  localparam int IDX_W         = $clog2(ATAN_ENTRIES);
  localparam int XY_W          = 27;
  localparam int ANG_W         = 32;
  localparam int RXY_W         = 17;
  localparam int PIPE_DEPTH    = NUM_ROT + 4;

  localparam logic signed [31:0] INV_GAIN = 32'sd1304065748;

  localparam logic [1:0] REG_MOVE_GAIN      = 2'd0;
  localparam logic [1:0] REG_TURN_GAIN      = 2'd1;
  localparam logic [1:0] REG_FIELD_ORIENTED = 2'd2;

  typedef struct packed {
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [ANG_W-1:0] z;
    logic signed [15:0]      x0;
    logic signed [15:0]      y0;
    logic signed [15:0]      t;
  } cord_t;

  function automatic logic signed [ANG_W-1:0] atan_lut(input logic [IDX_W-1:0] i);
    logic signed [ANG_W-1:0] a;
    case (i)
      5'd0:    a = 32'h20000000;
      5'd1:    a = 32'h12E4051E;
      5'd2:    a = 32'h09FB385B;
      5'd3:    a = 32'h051111D4;
      5'd4:    a = 32'h028B0D43;
      5'd5:    a = 32'h0145D7E1;
      5'd6:    a = 32'h00A2F61E;
      5'd7:    a = 32'h00517C55;
      5'd8:    a = 32'h0028BE53;
      5'd9:    a = 32'h00145F2F;
      5'd10:   a = 32'h000A2F98;
      5'd11:   a = 32'h000517CC;
      5'd12:   a = 32'h00028BE6;
      5'd13:   a = 32'h000145F3;
      5'd14:   a = 32'h0000A2FA;
      5'd15:   a = 32'h0000517D;
      5'd16:   a = 32'h000028BE;
      5'd17:   a = 32'h0000145F;
      5'd18:   a = 32'h00000A30;
      5'd19:   a = 32'h00000518;
      5'd20:   a = 32'h0000028C;
      5'd21:   a = 32'h00000146;
      5'd22:   a = 32'h000000A3;
      5'd23:   a = 32'h00000051;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

[sv/fodm_cordic_stage.sv]
// One registered CORDIC rotation stage.
module fodm_cordic_stage
  import fodm_pkg::*;
(
  input  logic             clk,
  input  logic             ld,
  input  logic [IDX_W-1:0] idx,
  input  cord_t            d,
  output cord_t            q
);

  logic signed [XY_W-1:0]  dx;
  logic signed [XY_W-1:0]  dy;
  logic signed [ANG_W-1:0] at;
  cord_t                   q_nxt;

  always_comb begin
    dx    = d.y >>> idx;
    dy    = d.x >>> idx;
    at    = atan_lut(idx);
    q_nxt = d;
    if (!d.z[ANG_W-1]) begin
      q_nxt.x = d.x - dx;
      q_nxt.y = d.y + dy;
      q_nxt.z = d.z - at;
    end else begin
      q_nxt.x = d.x + dx;
      q_nxt.y = d.y - dy;
      q_nxt.z = d.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      q <= q_nxt;
    end
  end

endmodule

[sv/field_oriented_omni_drive_mixer_unit.sv]
// Omni drive mixer top: field-oriented CORDIC rotation, gain and four-wheel mix.
// Stages in order: input fold, rotation, gain correction, products, mix output.
// Throughput: one request per cycle unless out_tready stalls; each register
// loads when empty or when the one after it moves, so bubbles collapse and a stall
// loses nothing. Rate set by one CORDIC iteration per register stage.
// Reset (rst_n low, synchronous): pipeline emptied, gains 1.0, field mode off.
`include "field_oriented_omni_drive_mixer_unit_defines.svh"
module field_oriented_omni_drive_mixer_unit
  import fodm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // stick_x, stick_y, turn_stick, heading_angle
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // left_drive, right_drive, front_drive, rear_drive
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_data
);

  localparam int POS_G = NUM_ROT + 1;
  localparam int POS_M = NUM_ROT + 2;
  localparam int POS_O = NUM_ROT + 3;

  logic [14:0] move_gain_r;
  logic [14:0] turn_gain_r;
  logic        field_oriented_r;

  logic [PIPE_DEPTH-1:0] v_r;
  logic [PIPE_DEPTH-1:0] v_nxt;
  logic [PIPE_DEPTH-1:0] adv;

  cord_t s0_nxt;
  cord_t s0_r;
  cord_t cd [0:NUM_ROT];

  logic signed [ANG_W-1:0] z_in;
  logic signed [XY_W-1:0]  x_in;
  logic signed [XY_W-1:0]  y_in;

  logic signed [RXY_W-1:0] gx_r, gy_r, gx_nxt, gy_nxt;
  logic signed [15:0]      gx0_r, gy0_r, gt_r;
  logic signed [58:0]      px_full, py_full;

  logic signed [RXY_W-1:0] xs, ys;
  logic signed [32:0]      mx_r, my_r, mx_nxt, my_nxt;
  logic signed [31:0]      mt_r, mt_nxt;

  logic signed [15:0] left_r, right_r, front_r, rear_r;
  logic signed [15:0] left_nxt, right_nxt, front_nxt, rear_nxt;

  function automatic logic signed [15:0] mix_sat(input logic signed [32:0] a,
                                                 input logic signed [31:0] t);
    logic signed [34:0] s;
    logic signed [20:0] r;
    s = 35'(a) + 35'(t) + 35'sd8192;
    r = 21'(s >>> 14);
    if (r > 21'sd32767) begin
      return 16'sd32767;
    end else if (r < -21'sd32767) begin
      return -16'sd32767;
    end
    return 16'(r);
  endfunction

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      move_gain_r      <= 15'd16384;
      turn_gain_r      <= 15'd16384;
      field_oriented_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MOVE_GAIN:      move_gain_r      <= cfg_data;
        REG_TURN_GAIN:      turn_gain_r      <= cfg_data;
        REG_FIELD_ORIENTED: field_oriented_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // pipeline advance and valid bits
  always_comb begin
    adv[PIPE_DEPTH-1] = !v_r[PIPE_DEPTH-1] || out_tready;
    for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
    v_nxt[0] = adv[0] ? in_tvalid : v_r[0];
    for (int k = 1; k < PIPE_DEPTH; k++) begin
      v_nxt[k] = adv[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_tready  = adv[0];
  assign out_tvalid = v_r[POS_O];

  // stage 0: angle negate and quadrant fold
  always_comb begin
    z_in = {16'(16'd0 - in_tdata[63:48]), 16'd0};
    x_in = XY_W'($signed(in_tdata[15:0])) <<< 8;
    y_in = XY_W'($signed(in_tdata[31:16])) <<< 8;
    s0_nxt.x0 = $signed(in_tdata[15:0]);
    s0_nxt.y0 = $signed(in_tdata[31:16]);
    s0_nxt.t  = $signed(in_tdata[47:32]);
    if (z_in > 32'sh40000000 || z_in < -32'sh40000000) begin
      s0_nxt.x = -x_in;
      s0_nxt.y = -y_in;
      s0_nxt.z = {~z_in[ANG_W-1], z_in[ANG_W-2:0]};
    end else begin
      s0_nxt.x = x_in;
      s0_nxt.y = y_in;
      s0_nxt.z = z_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s0_r <= s0_nxt;
    end
  end

  assign cd[0] = s0_r;

  // rotation stages
  for (genvar i = 0; i < NUM_ROT; i++) begin : g_rot
    fodm_cordic_stage u_stage (
      .clk (clk),
      .ld  (adv[i+1]),
      .idx (IDX_W'(i)),
      .d   (cd[i]),
      .q   (cd[i+1])
    );
  end

  // gain correction and round to Q15
  always_comb begin
    px_full = $signed(cd[NUM_ROT].x) * INV_GAIN + (59'sd1 <<< 38);
    py_full = $signed(cd[NUM_ROT].y) * INV_GAIN + (59'sd1 <<< 38);
    gx_nxt  = RXY_W'(px_full >>> 39);
    gy_nxt  = RXY_W'(py_full >>> 39);
  end

  always_ff @(posedge clk) begin
    if (adv[POS_G]) begin
      gx_r  <= gx_nxt;
      gy_r  <= gy_nxt;
      gx0_r <= cd[NUM_ROT].x0;
      gy0_r <= cd[NUM_ROT].y0;
      gt_r  <= cd[NUM_ROT].t;
    end
  end

  // vector select and gain products
  always_comb begin
    xs     = field_oriented_r ? gx_r : RXY_W'(gx0_r);
    ys     = field_oriented_r ? gy_r : RXY_W'(gy0_r);
    mx_nxt = 33'(xs * $signed({1'b0, move_gain_r}));
    my_nxt = 33'(ys * $signed({1'b0, move_gain_r}));
    mt_nxt = 32'(gt_r * $signed({1'b0, turn_gain_r}));
  end

  always_ff @(posedge clk) begin
    if (adv[POS_M]) begin
      mx_r <= mx_nxt;
      my_r <= my_nxt;
      mt_r <= mt_nxt;
    end
  end

  // mix, round and saturate
  always_comb begin
    left_nxt  = mix_sat(-my_r, mt_r);
    right_nxt = mix_sat(my_r, mt_r);
    front_nxt = mix_sat(mx_r, mt_r);
    rear_nxt  = mix_sat(-mx_r, mt_r);
  end

  always_ff @(posedge clk) begin
    if (adv[POS_O]) begin
      left_r  <= left_nxt;
      right_r <= right_nxt;
      front_r <= front_nxt;
      rear_r  <= rear_nxt;
    end
  end

  assign out_tdata = {rear_r, front_r, right_r, left_r};

  `FODM_ASSERT_IMPL(a_full_stall, (&v_r) && !out_tready, !in_tready)
  `FODM_ASSERT_NEXT(a_enter, in_tvalid && in_tready, v_r[0])
  `FODM_ASSERT_NEXT(a_drain, out_tvalid && out_tready && !v_r[POS_M], !out_tvalid)
  `FODM_ASSERT_IMPL(a_sat_range, out_tvalid,
    out_tdata[15:0] != 16'h8000 && out_tdata[31:16] != 16'h8000 &&
    out_tdata[47:32] != 16'h8000 && out_tdata[63:48] != 16'h8000)

endmodule
